// ===== design/cmac_pkg.sv =====
// ----------------------------------------------------------------------------
// cmac_pkg
// shared types, constants and aes helper functions for the cmac engine
// ----------------------------------------------------------------------------
package cmac_pkg;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
    logic        final_block;
  } in_req_t;

  typedef struct packed {
    logic [63:0] mac_high;
    logic [63:0] mac_low;
  } out_req_t;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  localparam logic [7:0]   RCON_FIRST = 8'h01;
  localparam logic [7:0]   GF8_POLY   = 8'h1b;
  localparam logic [127:0] GF128_POLY = 128'h87;
  localparam logic [7:0]   PAD_BYTE   = 8'h80;
  localparam logic [3:0]   LAST_ROUND = 4'd10;

  // start/done handshake between sequencer and aes core
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } core_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF8_POLY : 8'h00);
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? GF128_POLY : 128'h0);
  endfunction

endpackage

// ===== design/cmac_aes_core.sv =====
// ----------------------------------------------------------------------------
// cmac_aes_core
// iterative aes-128 encryptor, one round per cycle, key expanded on the fly
// ----------------------------------------------------------------------------
module cmac_aes_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [127:0]      key,
  input  logic [127:0]      block,
  output logic [127:0]      result,
  output cmac_pkg::core_ctl_t ctl
);

  logic [127:0] state_r, state_nxt;
  logic [127:0] rkey_r, rkey_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [3:0]   round_r, round_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;

  logic [7:0]   sb [16];
  logic [7:0]   nb [16];
  logic [7:0]   mb [16];
  logic [7:0]   kb [16];
  logic [7:0]   kn [16];
  logic [31:0]  tw;

  // byte i sits in bits 127-8i
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = state_r[127-8*i -: 8];
      kb[i] = rkey_r[127-8*i -: 8];
    end
    tw = {cmac_pkg::sbox(kb[13]) ^ rcon_r, cmac_pkg::sbox(kb[14]),
          cmac_pkg::sbox(kb[15]), cmac_pkg::sbox(kb[12])};
    for (int i = 0; i < 4; i++) kn[i] = kb[i] ^ tw[31-8*i -: 8];
    for (int i = 4; i < 16; i++) kn[i] = kb[i] ^ kn[i-4];
    // sub bytes and shift rows
    for (int i = 0; i < 16; i++) begin
      nb[i] = cmac_pkg::sbox(sb[((((i>>2) + (i&3)) & 3) << 2) + (i&3)]);
    end
    // mix columns, skipped in the last round
    for (int c = 0; c < 4; c++) begin
      if (round_r != cmac_pkg::LAST_ROUND - 4'd1) begin
        mb[4*c]   = cmac_pkg::xtime(nb[4*c]) ^ cmac_pkg::xtime(nb[4*c+1]) ^ nb[4*c+1]
                    ^ nb[4*c+2] ^ nb[4*c+3];
        mb[4*c+1] = nb[4*c] ^ cmac_pkg::xtime(nb[4*c+1]) ^ cmac_pkg::xtime(nb[4*c+2])
                    ^ nb[4*c+2] ^ nb[4*c+3];
        mb[4*c+2] = nb[4*c] ^ nb[4*c+1] ^ cmac_pkg::xtime(nb[4*c+2])
                    ^ cmac_pkg::xtime(nb[4*c+3]) ^ nb[4*c+3];
        mb[4*c+3] = cmac_pkg::xtime(nb[4*c]) ^ nb[4*c] ^ nb[4*c+1] ^ nb[4*c+2]
                    ^ cmac_pkg::xtime(nb[4*c+3]);
      end else begin
        mb[4*c]   = nb[4*c];
        mb[4*c+1] = nb[4*c+1];
        mb[4*c+2] = nb[4*c+2];
        mb[4*c+3] = nb[4*c+3];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    rkey_nxt  = rkey_r;
    rcon_nxt  = rcon_r;
    round_nxt = round_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      state_nxt = block ^ key;
      rkey_nxt  = key;
      rcon_nxt  = cmac_pkg::RCON_FIRST;
      round_nxt = 4'd0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      for (int i = 0; i < 16; i++) begin
        state_nxt[127-8*i -: 8] = mb[i] ^ kn[i];
        rkey_nxt[127-8*i -: 8]  = kn[i];
      end
      rcon_nxt  = cmac_pkg::xtime(rcon_r);
      round_nxt = round_r + 4'd1;
      if (round_r == cmac_pkg::LAST_ROUND - 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    rkey_r  <= rkey_nxt;
    rcon_r  <= rcon_nxt;
    if (!rst_n) begin
      round_r <= 4'd0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      round_r <= round_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  assign result    = state_r;
  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> round_r < cmac_pkg::LAST_ROUND) else $error("round overrun");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && round_r == cmac_pkg::LAST_ROUND - 4'd1 && !start) |=> done_r)
    else $error("missing done");

endmodule

// ===== design/aes128_cmac_engine.sv =====
// ----------------------------------------------------------------------------
// aes128_cmac_engine
// aes-128 cmac over 16-byte message blocks, one block per request
// ----------------------------------------------------------------------------
// A message arrives as a series of input requests, the last one flagged by
// final_block; only that one yields a result request holding the 128-bit mac.
// The first block of a message first runs 10 aes rounds to derive the
// subkey from aes(key, 0), then 10 rounds for the block, with the load,
// subkey handoff and writeback steps around them; every later block runs
// its own 10 rounds with load and writeback. A final block then keeps its
// mac at the output until it is taken. The single iterative aes core runs
// one round per cycle. Input is not taken while a block is in flight or while a
// finished mac still waits at the output. The key is to be written through the
// cfg port only while the engine is idle; the engine does not enforce this.
module aes128_cmac_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cmac_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cmac_pkg::out_req_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SUBK  = 5'b00010,
    ST_BLOCK = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  logic [63:0]    key_high_r, key_low_r;
  logic [127:0]   chain_r, chain_nxt;
  logic [127:0]   k1_r, k1_nxt;
  logic           open_r, open_nxt;
  cmac_pkg::in_req_t req_r;
  logic [127:0]   mac_r, mac_nxt;

  logic           core_start;
  logic [127:0]   core_block;
  logic [127:0]   core_result;
  cmac_pkg::core_ctl_t core_ctl;

  logic           in_fire;
  cmac_pkg::in_req_t cur_req;
  logic [127:0]   cur_blk;
  logic [127:0]   padded;
  logic [127:0]   masked;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = '{mac_high: mac_r[127:64], mac_low: mac_r[63:0]};

  // block being folded: straight from the input on a continuing block,
  // from the held request once the subkey of a new message is ready
  assign cur_req = (state_r == ST_IDLE) ? in_data : req_r;
  assign cur_blk = {cur_req.data_high, cur_req.data_low};

  // last-block padding: keep leading bytes, 0x80 marker, zeros after
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < cur_req.byte_count) padded[127-8*i -: 8] = cur_blk[127-8*i -: 8];
      else if (5'(i) == cur_req.byte_count) padded[127-8*i -: 8] = cmac_pkg::PAD_BYTE;
      else padded[127-8*i -: 8] = 8'h00;
    end
    if (!cur_req.final_block) masked = cur_blk;
    else if (cur_req.byte_count >= 5'd16) masked = cur_blk ^ k1_r;
    else masked = padded ^ cmac_pkg::gf_double(k1_r);
  end

  always_comb begin
    state_nxt  = state_r;
    chain_nxt  = chain_r;
    k1_nxt     = k1_r;
    open_nxt   = open_r;
    mac_nxt    = mac_r;
    core_start = 1'b0;
    core_block = chain_r ^ masked;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          core_start = 1'b1;
          if (!open_r) begin
            // new message: encrypt zero block to get l
            core_block = 128'h0;
            chain_nxt  = 128'h0;
            state_nxt  = ST_SUBK;
          end else begin
            state_nxt  = ST_WAIT;
          end
        end
      end
      ST_SUBK: begin
        if (core_ctl.done) begin
          k1_nxt    = cmac_pkg::gf_double(core_result);
          open_nxt  = 1'b1;
          state_nxt = ST_BLOCK;
        end
      end
      ST_BLOCK: begin
        // held block now has k1 ready, chain is zero
        core_start = 1'b1;
        state_nxt  = ST_WAIT;
      end
      ST_WAIT: begin
        if (core_ctl.done) begin
          if (req_r.final_block) begin
            mac_nxt   = core_result;
            chain_nxt = 128'h0;
            open_nxt  = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            chain_nxt = core_result;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  cmac_aes_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (core_start),
    .key    ({key_high_r, key_low_r}),
    .block  (core_block),
    .result (core_result),
    .ctl    (core_ctl)
  );

  always_ff @(posedge clk) begin
    k1_r  <= k1_nxt;
    mac_r <= mac_nxt;
    if (in_fire) req_r <= in_data;
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      chain_r    <= 128'h0;
      open_r     <= 1'b0;
      key_high_r <= 64'h0;
      key_low_r  <= 64'h0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      open_r  <= open_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cmac_pkg::CFG_KEY_HIGH) key_high_r <= cfg_data;
        else key_low_r <= cfg_data;
      end
    end
  end

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    core_start |-> !core_ctl.busy) else $error("core restarted while busy");
  a_out_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && core_ctl.done && req_r.final_block) |=> out_valid)
    else $error("mac not presented");
  a_closed_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !open_r) else $error("message still open at output");

endmodule

// ===== dv/aes128_cmac_checker.sv =====
// ----------------------------------------------------------------------------
// aes128_cmac_checker
// watches the block and config channels, predicts each cmac and compares it
// ----------------------------------------------------------------------------
module aes128_cmac_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  cmac_pkg::in_req_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  cmac_pkg::out_req_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_macs,
  output int                 macs_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]   sub_lut [256];
  logic [127:0] key_reg;
  logic [127:0] chain_acc;
  logic [127:0] k1_reg;
  logic         msg_open;
  cmac_pkg::out_req_t mac_queue [$];

  function automatic logic [7:0] mul2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] dbl128(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

  // byte i of a 128-bit word, byte 0 in the top bits
  function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                               input logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] k [16];
    logic [7:0] n [16];
    logic [7:0] t [4];
    logic [7:0] rc, a, b, c, d;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      k[i] = key[127-8*i -: 8];
      s[i] = pt[127-8*i -: 8] ^ k[i];
    end
    for (int r = 1; r <= 10; r++) begin
      t[0] = sub_lut[k[13]] ^ rc;
      t[1] = sub_lut[k[14]];
      t[2] = sub_lut[k[15]];
      t[3] = sub_lut[k[12]];
      for (int i = 0; i < 4; i++) k[i] = k[i] ^ t[i];
      for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
      rc = mul2(rc);
      for (int i = 0; i < 16; i++)
        n[i] = sub_lut[s[((((i >> 2) + (i & 3)) & 3) << 2) + (i & 3)]];
      if (r < 10) begin
        for (int i = 0; i < 16; i += 4) begin
          a = n[i]; b = n[i+1]; c = n[i+2]; d = n[i+3];
          n[i]   = mul2(a) ^ mul2(b) ^ b ^ c ^ d;
          n[i+1] = a ^ mul2(b) ^ mul2(c) ^ c ^ d;
          n[i+2] = a ^ b ^ mul2(c) ^ mul2(d) ^ d;
          n[i+3] = mul2(a) ^ a ^ b ^ c ^ mul2(d);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = n[i] ^ k[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  // build the forward sbox from gf(2^8) inverse and the affine map
  initial begin
    logic [7:0] p, q, x;
    p = 8'h01; q = 8'h01;
    sub_lut[0] = 8'h63;
    do begin
      p = p ^ mul2(p);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q = q ^ 8'h09;
      x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
            ^ {q[3:0], q[7:4]};
      sub_lut[p] = x ^ 8'h63;
    end while (p != 8'h01);
  end

  // pad and mask a final block before it is folded into the chain
  function automatic logic [127:0] final_mask(input cmac_pkg::in_req_t req,
                                              input logic [127:0] k1);
    logic [127:0] blk;
    blk = {req.data_high, req.data_low};
    if (req.byte_count >= 16) return blk ^ k1;
    for (int i = 0; i < 16; i++)
      if (i > req.byte_count) blk[127-8*i -: 8] = 8'h00;
      else if (i == req.byte_count) blk[127-8*i -: 8] = 8'h80;
    return blk ^ dbl128(k1);
  endfunction

  always_ff @(posedge clk) begin
    cmac_pkg::out_req_t want;
    logic [127:0] blk;
    int errs;
    errs = 0;
    if (!rst_n) begin
      key_reg <= '0;
      chain_acc <= '0;
      msg_open <= 1'b0;
      fail_count <= 0;
      macs_checked <= 0;
      pending_macs <= 0;
      mac_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cmac_pkg::CFG_KEY_HIGH) key_reg[127:64] <= cfg_data;
        else key_reg[63:0] <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        // first block of a message derives k1 from aes(key, 0)
        if (!msg_open) k1_reg = dbl128(aes_encrypt(key_reg, '0));
        blk = in_data.final_block ? final_mask(in_data, k1_reg)
                                  : {in_data.data_high, in_data.data_low};
        blk = aes_encrypt(key_reg, (msg_open ? chain_acc : 128'h0) ^ blk);
        if (in_data.final_block) begin
          mac_queue.push_back(cmac_pkg::out_req_t'(blk));
          chain_acc <= '0;
          msg_open <= 1'b0;
        end else begin
          chain_acc <= blk;
          msg_open <= 1'b1;
        end
      end
      if (out_valid && !out_stall) begin
        if (mac_queue.size() == 0) begin
          $display("%0t: unexpected mac, expected none, actual %h", $time, out_data);
          errs++;
        end else begin
          want = mac_queue.pop_front();
          macs_checked <= macs_checked + 1;
          if (want.mac_high !== out_data.mac_high) begin
            $display("%0t: mac_high expected %h actual %h", $time,
                     want.mac_high, out_data.mac_high);
            errs++;
          end
          if (want.mac_low !== out_data.mac_low) begin
            $display("%0t: mac_low expected %h actual %h", $time,
                     want.mac_low, out_data.mac_low);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_macs <= mac_queue.size();
    end
  end

endmodule

// ===== dv/aes128_cmac_engine_tb.sv =====
// ----------------------------------------------------------------------------
// aes128_cmac_engine_tb
// drives random and directed cmac messages under several keys and idling
// patterns; the checker predicts every mac and counts mismatches
// ----------------------------------------------------------------------------
module aes128_cmac_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cmac_pkg::in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cmac_pkg::out_req_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_index = cmac_pkg::CFG_KEY_HIGH;
  logic [63:0] cfg_data = '0;
  int       fail_count, pending_macs, macs_checked;

  // idle percentages per side, and a long receiver hold-off request
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       recv_hold = 1'b0;
  int       blocks_sent = 0;
  int       messages_sent = 0;

  always #1 clk = ~clk;

  aes128_cmac_engine dut (.*);

  aes128_cmac_checker checker_i (.*);

  // receiver: random stall, or a solid hold while recv_hold is set
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= recv_hold || ($urandom_range(99, 0) < recv_idle_pct);
  end

  // offer one block and wait for it to be taken; random idle cycles first.
  // valid stays up after the accept so back-to-back blocks need no gap;
  // drain drops it once the sender stops
  task automatic send_block(input logic [127:0] data, input int count,
                            input bit last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_high: data[127:64], data_low: data[63:0],
                 byte_count: count[4:0], final_block: last};
    do @(posedge clk); while (in_stall);
    blocks_sent++;
    if (last) messages_sent++;
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // a message of n full blocks then a final block with the given count
  task automatic send_message(input int n, input int count);
    for (int i = 0; i < n; i++) send_block(rand128(), $urandom_range(31, 0), 1'b0);
    send_block(rand128(), count, 1'b1);
  endtask

  // stop sending, wait for every mac, then settle so the engine is idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_macs != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_key(input logic [127:0] key);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? cmac_pkg::CFG_KEY_HIGH : cmac_pkg::CFG_KEY_LOW;
      cfg_data <= (i == 0) ? key[127:64] : key[63:0];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random byte count that favors the final-block cases
  function automatic int rand_count();
    case ($urandom_range(5, 0))
      0: return 0;
      1: return 16;
      2: return $urandom_range(31, 17);
      default: return $urandom_range(15, 1);
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero key, empty message, full and oversized last blocks
    send_block('0, 0, 1'b1);
    send_block({128{1'b1}}, 16, 1'b1);
    send_block({128{1'b1}}, 31, 1'b1);
    send_block('0, 17, 1'b1);
    drain();
    write_key({128{1'b1}});
    for (int c = 1; c < 16; c += 2) send_block({128{1'b1}}, c, 1'b1);
    // non-final blocks ignore byte count
    send_block({128{1'b1}}, 0, 1'b0);
    send_block('0, 31, 1'b0);
    send_block(128'h8000_0000_0000_0001_8000_0000_0000_0001, 15, 1'b1);
    drain();
    // well-known key from the cmac test vectors
    write_key(128'h2b7e1516_28aed2a6_abf71588_09cf4f3c);
    send_block('0, 0, 1'b1);
    send_block(128'h6bc1bee2_2e409f96_e93d7e11_7393172a, 16, 1'b1);
    drain();

    // random phases: receiver idles, sender idles, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 79 : 0;
      recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 26 : 0;
      write_key((phase == 2) ? 128'h0 : rand128());
      while (blocks_sent < 600 * (phase + 1)) begin
        send_message($urandom_range(3, 0) == 0 ? $urandom_range(8, 0)
                                               : $urandom_range(2, 0),
                     rand_count());
        if ($urandom_range(15, 0) == 0) drain();
      end
      drain();
    end

    // receiver holds off while the sender keeps offering short messages
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_message(0, rand_count());
    join
    drain();
    write_key({$urandom, $urandom, 64'h0});
    repeat (40) send_message($urandom_range(2, 0), rand_count());

    drain();
    $display("covered %0d blocks in %0d messages under several keys, %0d macs checked",
             blocks_sent, messages_sent, macs_checked);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
